// File: src/vsme_pkg.sv
//------------------------------------------------------------------------------
// vsme_pkg
// Shared types and constants of the vector similarity metric engine.
//------------------------------------------------------------------------------
`default_nettype none

package vsme_pkg;

	localparam int unsigned ACC_W   = 48;
	localparam int unsigned ELEM_W  = 16;
	localparam int unsigned MAGN_W  = 24;
	localparam int unsigned TERM_W  = 34;
	localparam int unsigned QUO_W   = 15;
	localparam int unsigned CNT_W   = 4;

	localparam logic [1:0] METRIC_DOT  = 2'd0;
	localparam logic [1:0] METRIC_COS  = 2'd1;
	localparam logic [1:0] METRIC_DIST = 2'd2;

	localparam logic [ACC_W-1:0]  DENOM_MIN = ACC_W'(5);
	localparam logic [CNT_W-1:0]  DIV_STEPS = CNT_W'(QUO_W);
	localparam logic [ACC_W-1:0]  COS_MAX   = ACC_W'(32767);
	localparam logic [ACC_W-1:0]  COS_MIN   = {{(ACC_W-16){1'b1}}, 16'h8000};

	typedef enum logic [6:0] {
		ST_IN   = 7'b0000001,
		ST_MUL  = 7'b0000010,
		ST_ACC  = 7'b0000100,
		ST_FIN  = 7'b0001000,
		ST_DIV  = 7'b0010000,
		ST_SIGN = 7'b0100000,
		ST_OUT  = 7'b1000000
	} vsme_state_t;

	typedef struct packed {
		logic capture;
		logic mul;
		logic acc;
		logic fin;
		logic div_step;
		logic sign;
		logic out_load;
	} vsme_cmd_t;

	typedef struct packed {
		logic last;
		logic div_needed;
		logic div_done;
		logic out_free;
	} vsme_status_t;

endpackage

`default_nettype wire

// File: src/vector_similarity_metric_engine.sv
//------------------------------------------------------------------------------
// vector_similarity_metric_engine
// Dot product, cosine similarity or squared distance over Q1.15 vectors.
//------------------------------------------------------------------------------
// channel   dir  fields
// s_*       in   tdata: a_value, b_value, a_magnitude, b_magnitude; tlast; tuser
// m_*       out  tdata: result
// metric_*  in   metric register write
//
// Non-final element: capture, multiply, accumulate.
// Final element adds finish and result load; cosine with a live quotient adds
// divide steps (15 quotient bits from a restoring divider, one per cycle) and sign.
// Result waits in the output register; the next vector's elements are taken
// meanwhile and only the next result load stalls on m_tready.
// Reset clears the accumulator, the metric and the output valid.
//------------------------------------------------------------------------------
`default_nettype none

module vector_similarity_metric_engine
	import vsme_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          metric_we,
	input  wire logic [1:0]    metric_wdata,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [79:0]   s_tdata,   // a_value, b_value, a_magnitude, b_magnitude
	input  wire logic          s_tlast,
	input  wire logic          s_tuser,   // sizes_differ
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [47:0]        m_tdata    // result
);

	logic [1:0]    metric_q;
	vsme_cmd_t     cmd;
	vsme_status_t  status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_q <= METRIC_DOT;
		end else if (metric_we) begin
			metric_q <= metric_wdata;
		end
	end

	vsme_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	vsme_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.metric_q (metric_q),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.status   (status)
	);

endmodule

`default_nettype wire

// File: src/vsme_ctrl.sv
//------------------------------------------------------------------------------
// vsme_ctrl
// Sequencer: capture, multiply, accumulate, finish, divide, sign, load result.
//------------------------------------------------------------------------------
`default_nettype none

module vsme_ctrl
	import vsme_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire vsme_status_t status,
	output vsme_cmd_t         cmd
);

	vsme_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IN: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
				if (s_tvalid) state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = status.last ? ST_FIN : ST_IN;
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = status.div_needed ? ST_DIV : ST_OUT;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_done) state_d = ST_SIGN;
			end
			ST_SIGN: begin
				cmd.sign = 1'b1;
				state_d  = ST_OUT;
			end
			ST_OUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IN;
				end
			end
			default: begin
				state_d = ST_IN;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: src/vsme_dp.sv
//------------------------------------------------------------------------------
// vsme_dp
// Datapath: input registers, term multiplier, 48-bit accumulator,
// cosine quotient (one bit per cycle) and output register.
//------------------------------------------------------------------------------
`default_nettype none

module vsme_dp
	import vsme_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [79:0]       s_tdata,
	input  wire logic              s_tlast,
	input  wire logic              s_tuser,
	input  wire logic [1:0]        metric_q,
	input  wire logic              m_tready,
	output logic                   m_tvalid,
	output logic [ACC_W-1:0]       m_tdata,
	input  wire vsme_cmd_t         cmd,
	output vsme_status_t           status
);

	logic signed [ELEM_W-1:0]  a_s1, b_s1;
	logic [MAGN_W-1:0]         am_s1, bm_s1;
	logic                      last_s1, sizes_s1;
	logic signed [TERM_W-1:0]  term_q;
	logic [ACC_W-1:0]          prod_q;
	logic [ACC_W-1:0]          acc_q, sum_q, rem_q, res_q;
	logic [QUO_W-1:0]          quo_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      m_tvalid_q;

	logic signed [ELEM_W:0]    diff, op_a, op_b;
	logic [ACC_W-1:0]          acc_sum, mag;
	logic [ACC_W+1:0]          mag4;
	logic                      neg, is_cos, p_small, sat;
	logic [ACC_W:0]            rem2;
	logic                      ge;

	assign diff = {a_s1[ELEM_W-1], a_s1} - {b_s1[ELEM_W-1], b_s1};
	assign op_a = (metric_q == METRIC_DIST) ? diff : {a_s1[ELEM_W-1], a_s1};
	assign op_b = (metric_q == METRIC_DIST) ? diff : {b_s1[ELEM_W-1], b_s1};

	assign acc_sum = acc_q + {{(ACC_W-TERM_W){term_q[TERM_W-1]}}, term_q};

	assign neg     = sum_q[ACC_W-1];
	assign mag     = neg ? (~sum_q + ACC_W'(1)) : sum_q;
	assign mag4    = {mag, 2'b00};
	assign is_cos  = (metric_q == METRIC_COS);
	assign p_small = (prod_q < DENOM_MIN);
	assign sat     = (mag4 >= {2'b00, prod_q});

	assign rem2 = {rem_q, 1'b0};
	assign ge   = (rem2 >= {1'b0, prod_q});

	assign status.last       = last_s1;
	assign status.div_needed = is_cos && !sizes_s1 && !p_small && !sat;
	assign status.div_done   = (cnt_q == CNT_W'(1));
	assign status.out_free   = !m_tvalid_q || m_tready;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			a_s1     <= s_tdata[15:0];
			b_s1     <= s_tdata[31:16];
			am_s1    <= s_tdata[55:32];
			bm_s1    <= s_tdata[79:56];
			last_s1  <= s_tlast;
			sizes_s1 <= s_tuser;
		end
		if (cmd.mul) begin
			term_q <= TERM_W'(op_a * op_b);
			prod_q <= am_s1 * bm_s1;
		end
		if (cmd.acc && last_s1) begin
			sum_q <= acc_sum;
		end
		if (cmd.fin) begin
			priority if (!is_cos) begin
				res_q <= sum_q;
			end else if (sizes_s1 || p_small) begin
				res_q <= '0;
			end else if (sat) begin
				res_q <= neg ? COS_MIN : COS_MAX;
			end else begin
				res_q <= sum_q;
			end
			rem_q <= mag4[ACC_W-1:0];
			quo_q <= '0;
			cnt_q <= DIV_STEPS;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? ACC_W'(rem2 - {1'b0, prod_q}) : rem2[ACC_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
			cnt_q <= cnt_q - CNT_W'(1);
		end
		if (cmd.sign) begin
			res_q <= neg ? (~{{(ACC_W-QUO_W){1'b0}}, quo_q} + ACC_W'(1))
			             : {{(ACC_W-QUO_W){1'b0}}, quo_q};
		end
		if (cmd.out_load) begin
			m_tdata <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.acc) begin
				acc_q <= last_s1 ? '0 : acc_sum;
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

`default_nettype wire

// File: test/vector_similarity_metric_engine_tb.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// vector_similarity_metric_engine_tb
// Self-checking bench for the dot, cosine and squared distance engine.
//------------------------------------------------------------------------------
// A directed table covers the field extremes, every metric code, the small
// denominator, sizes that differ, cosine saturation and a metric change in
// the middle of a vector. Random phases follow: each metric code, then random
// ones; random vectors, magnitudes mostly derived from their elements in cosine
// mode, random gaps on both streams, and one phase with a long output hold-off.
// Results are compared with typed row values or the in-bench accumulator model.
//------------------------------------------------------------------------------

module vector_similarity_metric_engine_tb;
	import vsme_pkg::*;

	localparam logic [1:0]  METRIC_SPARE  = 2'd3;
	localparam int unsigned DIR_ROWS      = 21;
	localparam int unsigned RAND_ITEMS    = 1200;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned RX_HOLD       = 400;
	localparam int unsigned STALL_LIMIT   = 4000;
	localparam int unsigned REPORT_MAX    = 10;

	typedef struct packed {
		logic [15:0] a;
		logic [15:0] b;
		logic        last;
		logic [23:0] am;
		logic [23:0] bm;
		logic        sd;
	} pair_t;

	typedef struct packed {
		logic        set_metric;
		logic [1:0]  metric;
		pair_t       pair;
		logic        typed;
		logic [47:0] want;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        metric_we;
	logic [1:0]  metric_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic        s_tlast;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;

	// in-bench copy of the engine state
	logic [1:0]  metric_shadow;
	logic [47:0] acc_shadow;

	logic [47:0] expected_results [$];
	pair_t       vec_buf [$];
	dir_row_t    dir_rows [DIR_ROWS];

	bit          no_idle;
	bit          rx_hold_req;
	int unsigned mismatches;
	int unsigned requests_in;
	int unsigned results_out;
	int unsigned metric_writes;
	int unsigned run_len;
	int unsigned longest_run;
	int unsigned dot_results;
	int unsigned cos_results;
	int unsigned dist_results;

	vector_similarity_metric_engine dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.metric_we    (metric_we),
		.metric_wdata (metric_wdata),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] pick_element();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return ($urandom_range(0, 1) != 0) ? 16'h0000 : 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic int unsigned pick_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 6);
		if (r < 95)
			return $urandom_range(7, 24);
		return $urandom_range(25, 64);
	endfunction

	function automatic logic [23:0] magnitude_q816(input real sumsq, input real scale);
		real m;
		m = $sqrt(sumsq) * scale * 65536.0;
		if (m >= 16777215.0)
			return 24'hFFFFFF;
		return 24'(longint'(m));
	endfunction

	function automatic logic [47:0] cosine_q15(input logic [47:0] dot, input logic [23:0] am,
			input logic [23:0] bm);
		logic [47:0] mag;
		logic [63:0] prod;
		logic [63:0] quo;
		mag  = dot[47] ? -dot : dot;
		prod = 64'(am) * 64'(bm);
		if (prod < 64'(DENOM_MIN))
			return '0;
		if (64'(mag) * 64'd4 >= prod)
			quo = 64'd32768;
		else
			quo = (64'(mag) << 17) / prod;
		if (!dot[47])
			return (quo > 64'd32767) ? 48'd32767 : quo[47:0];
		return -quo[47:0];
	endfunction

	// Adds one element pair to the shadow accumulator; on last, yields the result.
	function automatic void accumulate_pair(input pair_t p, output bit emits,
			output logic [47:0] res);
		longint av;
		longint bv;
		longint t;
		av = longint'($signed(p.a));
		bv = longint'($signed(p.b));
		if (metric_shadow == METRIC_DIST)
			t = (av - bv) * (av - bv);
		else
			t = av * bv;
		acc_shadow = acc_shadow + 48'(t);
		run_len++;
		emits = p.last;
		res = '0;
		if (p.last) begin
			if (metric_shadow == METRIC_COS) begin
				res = p.sd ? 48'd0 : cosine_q15(acc_shadow, p.am, p.bm);
				cos_results++;
			end else if (metric_shadow == METRIC_DIST) begin
				res = acc_shadow;
				dist_results++;
			end else begin
				res = acc_shadow;
				dot_results++;
			end
			acc_shadow = '0;
			if (run_len > longest_run)
				longest_run = run_len;
			run_len = 0;
		end
	endfunction

	function automatic void note_failure(input string what, input logic [47:0] want,
			input logic [47:0] got);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
	endfunction

	// Entered at a rising edge; returns at the edge where the request is taken.
	task automatic send_pair(input pair_t p, input logic typed, input logic [47:0] want);
		int unsigned gap;
		bit          emits;
		logic [47:0] res;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {p.bm, p.am, p.b, p.a};
		s_tlast  <= p.last;
		s_tuser  <= p.sd;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		requests_in++;
		accumulate_pair(p, emits, res);
		if (emits)
			expected_results.push_back(typed ? want : res);
	endtask

	task automatic write_metric(input logic [1:0] m);
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		metric_we    <= 1'b1;
		metric_wdata <= m;
		@(posedge clk);
		metric_we     <= 1'b0;
		metric_shadow = m;
		metric_writes++;
	endtask

	task automatic build_vector(input int unsigned len, input bit closed);
		pair_t       e;
		real         sa;
		real         sb;
		int unsigned i;
		sa = 0.0;
		sb = 0.0;
		for (i = 0; i < len; i++) begin
			e.a    = pick_element();
			e.b    = pick_element();
			e.last = closed && (i == len - 1);
			e.am   = 24'($urandom());
			e.bm   = 24'($urandom());
			e.sd   = 1'($urandom_range(0, 1));
			sa += real'($signed(e.a)) * real'($signed(e.a)) / 1073741824.0;
			sb += real'($signed(e.b)) * real'($signed(e.b)) / 1073741824.0;
			if (e.last && metric_shadow == METRIC_COS) begin
				e.sd = ($urandom_range(0, 9) == 0);
				case ($urandom_range(0, 9))
					7: begin
						e.am = magnitude_q816(sa, 0.5);
						e.bm = magnitude_q816(sb, 0.5);
					end
					8: begin
						e.am = 24'($urandom());
						e.bm = 24'($urandom());
					end
					9: begin
						e.am = 24'($urandom_range(0, 2));
						e.bm = 24'($urandom_range(0, 3));
					end
					default: begin
						e.am = magnitude_q816(sa, 1.0);
						e.bm = magnitude_q816(sb, 1.0);
					end
				endcase
			end
			vec_buf.push_back(e);
		end
	endtask

	task automatic send_vectors();
		int unsigned i;
		for (i = 0; i < vec_buf.size(); i++)
			send_pair(vec_buf[i], 1'b0, '0);
		vec_buf.delete();
	endtask

	// output side: random ready with a long hold-off on request
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (rx_hold_req) begin
				m_tready <= 1'b0;
				repeat (RX_HOLD) @(posedge clk);
				rx_hold_req = 1'b0;
			end else begin
				int unsigned gap;
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				gap = pick_gap();
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin : result_check
		logic [47:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			results_out++;
			if (expected_results.size() == 0) begin
				note_failure("result with none pending", '0, m_tdata);
			end else begin
				want = expected_results.pop_front();
				if (m_tdata !== want)
					note_failure("result mismatch", want, m_tdata);
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no request accepted for %0d cycles", STALL_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int unsigned row;
		int unsigned phase_no;
		int unsigned rand_items;
		int unsigned budget;
		int unsigned sent;
		int unsigned len;
		logic [1:0]  m;

		arst_n        = 1'b0;
		metric_we     = 1'b0;
		metric_wdata  = METRIC_DOT;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tlast       = 1'b0;
		s_tuser       = 1'b0;
		metric_shadow = METRIC_DOT;
		acc_shadow    = '0;
		no_idle       = 1'b0;
		rx_hold_req   = 1'b0;
		mismatches    = 0;
		requests_in   = 0;
		results_out   = 0;
		metric_writes = 0;
		run_len       = 0;
		longest_run   = 0;
		dot_results   = 0;
		cos_results   = 0;
		dist_results  = 0;

		dir_rows = '{
			'{1'b0, METRIC_DOT,   '{16'h7FFF, 16'h7FFF, 1'b1, 24'h0, 24'h0, 1'b0},
				1'b1, 48'h0000_3FFF_0001},
			'{1'b0, METRIC_DOT,   '{16'h8000, 16'h8000, 1'b1, 24'h0, 24'h0, 1'b0},
				1'b1, 48'h0000_4000_0000},
			'{1'b0, METRIC_DOT,   '{16'h8000, 16'h7FFF, 1'b1, 24'h0, 24'h0, 1'b0},
				1'b1, 48'hFFFF_C000_8000},
			'{1'b0, METRIC_DOT,   '{16'h0064, 16'h00C8, 1'b0, 24'h0, 24'h0, 1'b0},
				1'b0, 48'h0},
			'{1'b0, METRIC_DOT,   '{16'hFFFD, 16'h0007, 1'b1, 24'hFFFFFF, 24'h0, 1'b1},
				1'b0, 48'h0},
			'{1'b1, METRIC_DIST,  '{16'h7FFF, 16'h8000, 1'b1, 24'h0, 24'h0, 1'b0},
				1'b1, 48'h0000_FFFE_0001},
			'{1'b0, METRIC_DIST,  '{16'h8000, 16'h7FFF, 1'b0, 24'h0, 24'h0, 1'b0},
				1'b0, 48'h0},
			'{1'b0, METRIC_DIST,  '{16'h0005, 16'h0005, 1'b1, 24'h0, 24'h0, 1'b0},
				1'b0, 48'h0},
			// exact quarter
			'{1'b1, METRIC_COS,   '{16'h4000, 16'h4000, 1'b1, 24'h010000, 24'h010000, 1'b0},
				1'b1, 48'd8192},
			// denominator below threshold
			'{1'b0, METRIC_COS,   '{16'h03E8, 16'h03E8, 1'b1, 24'h000001, 24'h000004, 1'b0},
				1'b1, 48'd0},
			// smallest live denominator, saturates
			'{1'b0, METRIC_COS,   '{16'h03E8, 16'h03E8, 1'b1, 24'h000001, 24'h000005, 1'b0},
				1'b1, 48'd32767},
			'{1'b0, METRIC_COS,   '{16'h03E8, 16'hFC18, 1'b1, 24'h000001, 24'h000005, 1'b0},
				1'b1, 48'hFFFF_FFFF_8000},
			// sizes differ
			'{1'b0, METRIC_COS,   '{16'h4000, 16'h4000, 1'b1, 24'h010000, 24'h010000, 1'b1},
				1'b1, 48'd0},
			'{1'b0, METRIC_COS,   '{16'h7FFF, 16'h7FFF, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 1'b0},
				1'b0, 48'h0},
			'{1'b0, METRIC_COS,   '{16'h7FFF, 16'h7FFF, 1'b1, 24'h000000, 24'hFFFFFF, 1'b0},
				1'b1, 48'd0},
			// metric switches before the last element
			'{1'b0, METRIC_COS,   '{16'h8000, 16'h8000, 1'b0, 24'hFFFFFF, 24'hFFFFFF, 1'b1},
				1'b0, 48'h0},
			'{1'b1, METRIC_DIST,  '{16'h0001, 16'hFFFF, 1'b1, 24'h0, 24'h0, 1'b0},
				1'b0, 48'h0},
			// unused code acts as dot
			'{1'b1, METRIC_SPARE, '{16'h8000, 16'h7FFF, 1'b1, 24'h0, 24'h0, 1'b0},
				1'b1, 48'hFFFF_C000_8000},
			'{1'b1, METRIC_DOT,   '{16'h0000, 16'h0000, 1'b1, 24'h0, 24'h0, 1'b0},
				1'b1, 48'd0},
			'{1'b1, METRIC_COS,   '{16'h0000, 16'h04D2, 1'b1, 24'h010000, 24'h010000, 1'b0},
				1'b1, 48'd0},
			'{1'b0, METRIC_COS,   '{16'h4000, 16'hC000, 1'b1, 24'h010000, 24'h010000, 1'b0},
				1'b1, 48'hFFFF_FFFF_E000}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < DIR_ROWS; row++) begin
			if (dir_rows[row].set_metric)
				write_metric(dir_rows[row].metric);
			send_pair(dir_rows[row].pair, dir_rows[row].typed, dir_rows[row].want);
		end

		phase_no   = 0;
		rand_items = 0;
		while (rand_items < RAND_ITEMS) begin
			case (phase_no)
				0: m = METRIC_DOT;
				1: m = METRIC_COS;
				2: m = METRIC_DIST;
				3: m = METRIC_SPARE;
				default: m = 2'($urandom_range(0, 3));
			endcase
			write_metric(m);
			no_idle = (phase_no == 2) || ($urandom_range(0, 4) == 0);
			if (phase_no == 2)
				rx_hold_req = 1'b1;
			budget = $urandom_range(60, 160);
			sent = 0;
			while (sent < budget) begin
				len = (phase_no == 2) ? $urandom_range(1, 3) : pick_length();
				build_vector(len, 1'b1);
				send_vectors();
				sent += len;
			end
			// leave a vector open across the next metric write
			if ($urandom_range(0, 2) == 0) begin
				len = $urandom_range(1, 4);
				build_vector(len, 1'b0);
				send_vectors();
				sent += len;
			end
			rand_items += sent;
			phase_no++;
		end

		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("ran %0d element requests, %0d results checked, %0d metric writes",
			requests_in, results_out, metric_writes);
		$display("results by metric: dot %0d, cosine %0d, distance %0d; longest vector %0d",
			dot_results, cos_results, dist_results, longest_run);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
